@@ hdl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the blocked interval selector
// Holds codes, control structs and fixed sizes used across the block.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_PROFILES = 5;
  localparam int SLOT_W       = 3;
  localparam int TOL_W        = 16;
  localparam int CFG_IDX_W    = 2;

  // load count value that marks an overflowed set
  localparam logic [SLOT_W-1:0] CNT_OVERFLOW = 3'd6;
  localparam logic [TOL_W-1:0]  TOL_RESET    = 16'd1;

  // input item kind and result kind codes
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
  localparam logic RESP_STATUS = 1'b0;
  localparam logic RESP_QUERY  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_PAIR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_NEAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_FAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EX
  } state_e;

  typedef enum logic [2:0] {
    PH_TIE2,
    PH_TIE4A,
    PH_TIE4B,
    PH_TIE4C,
    PH_MIN,
    PH_IV1,
    PH_IV1X,
    PH_IV2
  } phase_e;

  typedef enum logic [1:0] {
    TOL_PAIR,
    TOL_NEAR,
    TOL_FAR
  } tol_sel_e;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic              re;
    logic [SLOT_W-1:0] ra;
    logic [SLOT_W-1:0] rb;
  } mem_ctl_t;

  typedef struct packed {
    logic lt;
    logic tie;
    logic dir_ne;
  } cmp_res_t;

  typedef struct packed {
    logic              init;
    logic              wr_min;
    logic              min_sel_a;
    logic [SLOT_W-1:0] min_slot;
    logic              wr_a;
    logic              wr_b;
    logic [SLOT_W-1:0] slot_l;
    logic [SLOT_W-1:0] slot_r;
  } blk_wr_t;

  typedef struct packed {
    logic done;
    logic ok;
  } resp_t;

endpackage

@@ hdl/blocked_interval_selector.sv @@
// ----------------------------------------------------------------------------
// blocked_interval_selector: blocked duration intervals over candidate profiles
// Stages up to five profiles, builds the block, answers time queries.
// ----------------------------------------------------------------------------
//
//  channel   ports                                         direction
//  -------   --------------------------------------------  ---------
//  command   start_i, busy_o, kind_i, duration_i,          in
//            direction_i, last_i, query_time_i
//  result    done_o, resp_kind_o, calc_ok_o, blocked_o,    out
//            profile_valid_o, profile_slot_o
//  config    cfg_we_i, cfg_index_i, cfg_wdata_i            in
//
//  A command transfers at a clock edge with start_i high and busy_o low.
//  A load without last gives no result. A query gives its result in the
//  next cycle; queries may follow each other every cycle while idle.
//  A last load runs the calculation: each compare is a staging read, then
//  a step in the shared compare unit, and the status passes through the
//  result register. An overflowed set reports in the next cycle. Reset
//  clears the block, the load count and the sequencer; tolerances reset
//  to one. done_o is a one-cycle strobe the receiver cannot hold off.
//
module blocked_interval_selector #(
  parameter int TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [TIME_BITS-1:0]          duration_i,
  input  logic                          direction_i,
  input  logic                          last_i,
  input  logic [TIME_BITS-1:0]          query_time_i,
  // result channel
  output logic                          done_o,
  output logic                          resp_kind_o,
  output logic                          calc_ok_o,
  output logic                          blocked_o,
  output logic                          profile_valid_o,
  output logic [bis_pkg::SLOT_W-1:0]    profile_slot_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bis_pkg::TOL_W-1:0]     cfg_wdata_i
);

  localparam int SW = bis_pkg::SLOT_W;
  localparam int TW = bis_pkg::TOL_W;

  logic                 take;
  logic [TW-1:0]        tol_pair_q, tol_near_q, tol_far_q;

  bis_pkg::mem_ctl_t    mem_ctl;
  bis_pkg::cmp_res_t    cmp_res;
  bis_pkg::tol_sel_e    tol_sel;
  bis_pkg::blk_wr_t     blk_wr;
  bis_pkg::resp_t       resp;

  logic [TIME_BITS-1:0] a_dur, b_dur;
  logic                 a_dir, b_dir;
  logic                 q_blocked, q_valid;
  logic [SW-1:0]        q_slot;

  logic                 done_q, done_d;
  logic                 kind_q, kind_d;
  logic                 ok_q, ok_d;
  logic                 blk_q, blk_d;
  logic                 pv_q, pv_d;
  logic [SW-1:0]        slot_q, slot_d;

  // command transfer
  assign take = start_i && !busy_o;

  // tolerance registers; writes to an unused index drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_pair_q <= bis_pkg::TOL_RESET;
      tol_near_q <= bis_pkg::TOL_RESET;
      tol_far_q  <= bis_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bis_pkg::CFG_TIE_PAIR: tol_pair_q <= cfg_wdata_i;
        bis_pkg::CFG_TIE_NEAR: tol_near_q <= cfg_wdata_i;
        bis_pkg::CFG_TIE_FAR:  tol_far_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .kind_i    (kind_i),
    .last_i    (last_i),
    .res_i     (cmp_res),
    .busy_o    (busy_o),
    .mem_o     (mem_ctl),
    .tol_sel_o (tol_sel),
    .blk_o     (blk_wr),
    .resp_o    (resp)
  );

  bis_stage_mem #(.TIME_BITS(TIME_BITS)) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .wdur_i  (duration_i),
    .wdir_i  (direction_i),
    .a_dur_o (a_dur),
    .a_dir_o (a_dir),
    .b_dur_o (b_dur),
    .b_dir_o (b_dir)
  );

  bis_cmp_unit #(.TIME_BITS(TIME_BITS)) u_cmp (
    .a_dur_i    (a_dur),
    .a_dir_i    (a_dir),
    .b_dur_i    (b_dur),
    .b_dir_i    (b_dir),
    .tol_sel_i  (tol_sel),
    .tol_pair_i (tol_pair_q),
    .tol_near_i (tol_near_q),
    .tol_far_i  (tol_far_q),
    .res_o      (cmp_res)
  );

  bis_block #(.TIME_BITS(TIME_BITS)) u_block (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (blk_wr),
    .a_dur_i      (a_dur),
    .b_dur_i      (b_dur),
    .lt_i         (cmp_res.lt),
    .query_time_i (query_time_i),
    .q_blocked_o  (q_blocked),
    .q_valid_o    (q_valid),
    .q_slot_o     (q_slot)
  );

  // result register: a status from the sequencer, or a query answer taken
  // the cycle the query transfers; the two never coincide
  always_comb begin
    done_d = 1'b0;
    kind_d = kind_q;
    ok_d   = ok_q;
    blk_d  = blk_q;
    pv_d   = pv_q;
    slot_d = slot_q;
    if (resp.done) begin
      done_d = 1'b1;
      kind_d = bis_pkg::RESP_STATUS;
      ok_d   = resp.ok;
      blk_d  = 1'b0;
      pv_d   = 1'b0;
      slot_d = '0;
    end else if (take && kind_i == bis_pkg::KIND_QUERY) begin
      done_d = 1'b1;
      kind_d = bis_pkg::RESP_QUERY;
      ok_d   = 1'b0;
      blk_d  = q_blocked;
      pv_d   = q_valid;
      slot_d = q_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      kind_q <= bis_pkg::RESP_STATUS;
      ok_q   <= 1'b0;
      blk_q  <= 1'b0;
      pv_q   <= 1'b0;
      slot_q <= '0;
    end else begin
      done_q <= done_d;
      kind_q <= kind_d;
      ok_q   <= ok_d;
      blk_q  <= blk_d;
      pv_q   <= pv_d;
      slot_q <= slot_d;
    end
  end

  assign done_o          = done_q;
  assign resp_kind_o     = kind_q;
  assign calc_ok_o       = ok_q;
  assign blocked_o       = blk_q;
  assign profile_valid_o = pv_q;
  assign profile_slot_o  = slot_q;

endmodule

@@ hdl/bis_stage_mem.sv @@
// ----------------------------------------------------------------------------
// bis_stage_mem: staging store for candidate profiles
// One write port, two registered read ports; word is direction and duration.
// ----------------------------------------------------------------------------
module bis_stage_mem #(
  parameter int TIME_BITS = 48
) (
  input  logic                     clk_i,
  input  bis_pkg::mem_ctl_t        ctl_i,
  input  logic [TIME_BITS-1:0]     wdur_i,
  input  logic                     wdir_i,
  output logic [TIME_BITS-1:0]     a_dur_o,
  output logic                     a_dir_o,
  output logic [TIME_BITS-1:0]     b_dur_o,
  output logic                     b_dir_o
);

  localparam int W = TIME_BITS + 1;

  logic [W-1:0] mem_q [bis_pkg::MAX_PROFILES];
  logic [W-1:0] rda_q;
  logic [W-1:0] rdb_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= {wdir_i, wdur_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rda_q <= mem_q[ctl_i.ra];
      rdb_q <= mem_q[ctl_i.rb];
    end
  end

  assign a_dur_o = rda_q[TIME_BITS-1:0];
  assign a_dir_o = rda_q[TIME_BITS];
  assign b_dur_o = rdb_q[TIME_BITS-1:0];
  assign b_dir_o = rdb_q[TIME_BITS];

endmodule

@@ hdl/bis_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// bis_cmp_unit: shared compare unit
// One subtractor gives less-than and tolerance tie; an XOR, direction mismatch.
// ----------------------------------------------------------------------------
module bis_cmp_unit #(
  parameter int TIME_BITS = 48
) (
  input  logic [TIME_BITS-1:0]        a_dur_i,
  input  logic                        a_dir_i,
  input  logic [TIME_BITS-1:0]        b_dur_i,
  input  logic                        b_dir_i,
  input  bis_pkg::tol_sel_e           tol_sel_i,
  input  logic [bis_pkg::TOL_W-1:0]   tol_pair_i,
  input  logic [bis_pkg::TOL_W-1:0]   tol_near_i,
  input  logic [bis_pkg::TOL_W-1:0]   tol_far_i,
  output bis_pkg::cmp_res_t           res_o
);

  localparam int TW = bis_pkg::TOL_W;

  logic [TIME_BITS:0]   diff;
  logic                 borrow;
  logic [TIME_BITS-1:0] mag;
  logic                 hi_zero;
  logic [TW-1:0]        tol;
  logic                 tie;

  always_comb begin
    case (tol_sel_i)
      bis_pkg::TOL_PAIR: tol = tol_pair_i;
      bis_pkg::TOL_NEAR: tol = tol_near_i;
      bis_pkg::TOL_FAR:  tol = tol_far_i;
      default:           tol = tol_far_i;
    endcase
  end

  // when a < b the inverted difference is |a-b| - 1, so compare against tol - 1
  always_comb begin
    diff    = {1'b0, a_dur_i} - {1'b0, b_dur_i};
    borrow  = diff[TIME_BITS];
    mag     = borrow ? ~diff[TIME_BITS-1:0] : diff[TIME_BITS-1:0];
    hi_zero = (mag[TIME_BITS-1:TW] == '0);
    if (borrow) begin
      tie = hi_zero && (tol != '0) && (mag[TW-1:0] < (tol - TW'(1)));
    end else begin
      tie = hi_zero && (mag[TW-1:0] < tol);
    end
  end

  assign res_o.lt     = borrow;
  assign res_o.tie    = tie;
  assign res_o.dir_ne = a_dir_i ^ b_dir_i;

endmodule

@@ hdl/bis_block.sv @@
// ----------------------------------------------------------------------------
// bis_block: current block registers and query evaluation
// Holds minimum time and up to two intervals; answers a time query.
// ----------------------------------------------------------------------------
module bis_block #(
  parameter int TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bis_pkg::blk_wr_t              wr_i,
  input  logic [TIME_BITS-1:0]          a_dur_i,
  input  logic [TIME_BITS-1:0]          b_dur_i,
  input  logic                          lt_i,
  input  logic [TIME_BITS-1:0]          query_time_i,
  output logic                          q_blocked_o,
  output logic                          q_valid_o,
  output logic [bis_pkg::SLOT_W-1:0]    q_slot_o
);

  localparam int SW = bis_pkg::SLOT_W;

  logic                 valid_q, av_q, bv_q;
  logic [TIME_BITS-1:0] min_time_q, al_q, ar_q, bl_q, br_q;
  logic [SW-1:0]        min_slot_q, aslot_q, bslot_q;
  logic [TIME_BITS-1:0] lo, hi;
  logic [SW-1:0]        iv_slot;
  logic                 t_lt_min, t_gt_al, t_lt_ar, t_gt_bl, t_lt_br;

  always_comb begin
    lo      = lt_i ? a_dur_i : b_dur_i;
    hi      = lt_i ? b_dur_i : a_dur_i;
    iv_slot = lt_i ? wr_i.slot_r : wr_i.slot_l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      av_q    <= 1'b0;
      bv_q    <= 1'b0;
    end else if (wr_i.init) begin
      valid_q <= 1'b1;
      av_q    <= 1'b0;
      bv_q    <= 1'b0;
    end else begin
      if (wr_i.wr_a) av_q <= 1'b1;
      if (wr_i.wr_b) bv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_min) begin
      min_time_q <= wr_i.min_sel_a ? a_dur_i : b_dur_i;
      min_slot_q <= wr_i.min_slot;
    end
    if (wr_i.wr_a) begin
      al_q    <= lo;
      ar_q    <= hi;
      aslot_q <= iv_slot;
    end
    if (wr_i.wr_b) begin
      bl_q    <= lo;
      br_q    <= hi;
      bslot_q <= iv_slot;
    end
  end

  always_comb begin
    t_lt_min = query_time_i < min_time_q;
    t_gt_al  = al_q < query_time_i;
    t_lt_ar  = query_time_i < ar_q;
    t_gt_bl  = bl_q < query_time_i;
    t_lt_br  = query_time_i < br_q;
    if (!valid_q) begin
      q_blocked_o = 1'b1;
      q_slot_o    = '0;
    end else begin
      q_blocked_o = t_lt_min || (av_q && t_gt_al && t_lt_ar) || (bv_q && t_gt_bl && t_lt_br);
      if (bv_q && !t_lt_br) begin
        q_slot_o = bslot_q;
      end else if (av_q && !t_lt_ar) begin
        q_slot_o = aslot_q;
      end else begin
        q_slot_o = min_slot_q;
      end
    end
  end

  assign q_valid_o = valid_q;

endmodule

@@ hdl/bis_ctrl.sv @@
// ----------------------------------------------------------------------------
// bis_ctrl: load counter and calculation sequencer
// Stages loads and steps the shared compare unit through the case rules.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 kind_i,
  input  logic                 last_i,
  input  bis_pkg::cmp_res_t    res_i,
  output logic                 busy_o,
  output bis_pkg::mem_ctl_t    mem_o,
  output bis_pkg::tol_sel_e    tol_sel_o,
  output bis_pkg::blk_wr_t     blk_o,
  output bis_pkg::resp_t       resp_o
);

  localparam int SW = bis_pkg::SLOT_W;

  bis_pkg::state_e state_q, state_d;
  bis_pkg::phase_e phase_q, phase_d;
  logic [SW-1:0]   cnt_q, cnt_d, cnt_nx;
  logic [SW-1:0]   n_q, n_d;
  logic [SW-1:0]   i_q, i_d;
  logic [SW-1:0]   m_q, m_d;
  logic            skip1_q, skip1_d;
  logic            alt_q, alt_d;
  logic [SW-1:0]   e1, e2, e3, e4;
  logic [SW-1:0]   la, lb, addr_a, addr_b;

  // logical candidate index to load slot; drop slot one after a pair removal
  function automatic logic [SW-1:0] phys(input logic [SW-1:0] idx, input logic skip);
    return (skip && idx != '0) ? idx + SW'(1) : idx;
  endfunction

  function automatic logic [SW-1:0] mod_add(input logic [SW-1:0] a,
                                            input logic [SW-1:0] k,
                                            input logic [SW-1:0] n);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, k};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[SW-1:0];
  endfunction

  always_comb begin
    e1 = mod_add(m_q, SW'(1), n_q);
    e2 = mod_add(m_q, SW'(2), n_q);
    e3 = mod_add(m_q, SW'(3), n_q);
    e4 = mod_add(m_q, SW'(4), n_q);
    tol_sel_o = bis_pkg::TOL_FAR;
    unique case (phase_q)
      bis_pkg::PH_TIE2: begin
        la = SW'(0); lb = SW'(1); tol_sel_o = bis_pkg::TOL_PAIR;
      end
      bis_pkg::PH_TIE4A: begin
        la = SW'(0); lb = SW'(1); tol_sel_o = bis_pkg::TOL_NEAR;
      end
      bis_pkg::PH_TIE4B: begin
        la = SW'(2); lb = SW'(3);
      end
      bis_pkg::PH_TIE4C: begin
        la = SW'(0); lb = SW'(3);
      end
      bis_pkg::PH_MIN: begin
        la = i_q; lb = m_q;
      end
      bis_pkg::PH_IV1: begin
        if (n_q == SW'(2)) begin
          la = m_q; lb = e1;
        end else begin
          la = e1; lb = e2;
        end
      end
      bis_pkg::PH_IV1X: begin
        la = e1; lb = e4;
      end
      bis_pkg::PH_IV2: begin
        la = alt_q ? e2 : e3;
        lb = alt_q ? e3 : e4;
      end
      default: begin
        la = '0; lb = '0;
      end
    endcase
    addr_a = phys(la, skip1_q);
    addr_b = phys(lb, skip1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bis_pkg::ST_IDLE;
      phase_q <= bis_pkg::PH_MIN;
      cnt_q   <= '0;
      n_q     <= '0;
      i_q     <= '0;
      m_q     <= '0;
      skip1_q <= 1'b0;
      alt_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      i_q     <= i_d;
      m_q     <= m_d;
      skip1_q <= skip1_d;
      alt_q   <= alt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    i_d     = i_q;
    m_d     = m_q;
    skip1_d = skip1_q;
    alt_d   = alt_q;

    cnt_nx  = (cnt_q < SW'(bis_pkg::MAX_PROFILES)) ? cnt_q + SW'(1) : bis_pkg::CNT_OVERFLOW;

    mem_o.we    = 1'b0;
    mem_o.waddr = cnt_q;
    mem_o.re    = 1'b0;
    mem_o.ra    = addr_a;
    mem_o.rb    = addr_b;

    blk_o.init      = 1'b0;
    blk_o.wr_min    = 1'b0;
    blk_o.min_sel_a = res_i.lt;
    blk_o.min_slot  = res_i.lt ? addr_a : addr_b;
    blk_o.wr_a      = 1'b0;
    blk_o.wr_b      = 1'b0;
    blk_o.slot_l    = addr_a;
    blk_o.slot_r    = addr_b;

    resp_o.done = 1'b0;
    resp_o.ok   = 1'b0;

    unique case (state_q)
      bis_pkg::ST_IDLE: begin
        if (take_i && kind_i == bis_pkg::KIND_LOAD) begin
          mem_o.we = (cnt_q < SW'(bis_pkg::MAX_PROFILES));
          cnt_d    = cnt_nx;
          if (last_i) begin
            cnt_d   = '0;
            n_d     = cnt_nx;
            i_d     = '0;
            m_d     = '0;
            skip1_d = 1'b0;
            alt_d   = 1'b0;
            case (cnt_nx)
              SW'(1), SW'(3), SW'(5): begin
                phase_d = bis_pkg::PH_MIN;
                state_d = bis_pkg::ST_RD;
              end
              SW'(2): begin
                phase_d = bis_pkg::PH_TIE2;
                state_d = bis_pkg::ST_RD;
              end
              SW'(4): begin
                phase_d = bis_pkg::PH_TIE4A;
                state_d = bis_pkg::ST_RD;
              end
              default: begin
                // overflowed set: report failure at once, keep block
                resp_o.done = 1'b1;
              end
            endcase
          end
        end
      end

      bis_pkg::ST_RD: begin
        mem_o.re = 1'b1;
        state_d  = bis_pkg::ST_EX;
      end

      bis_pkg::ST_EX: begin
        state_d = bis_pkg::ST_RD;
        unique case (phase_q)
          bis_pkg::PH_TIE2: begin
            blk_o.init   = 1'b1;
            blk_o.wr_min = 1'b1;
            if (res_i.tie) begin
              blk_o.min_sel_a = 1'b1;
              blk_o.min_slot  = addr_a;
              resp_o.done     = 1'b1;
              resp_o.ok       = 1'b1;
              state_d         = bis_pkg::ST_IDLE;
            end else begin
              m_d     = res_i.lt ? SW'(0) : SW'(1);
              phase_d = bis_pkg::PH_IV1;
            end
          end
          bis_pkg::PH_TIE4A: begin
            if (res_i.tie && res_i.dir_ne) begin
              skip1_d = 1'b1;
              n_d     = SW'(3);
              phase_d = bis_pkg::PH_MIN;
            end else begin
              phase_d = bis_pkg::PH_TIE4B;
            end
          end
          bis_pkg::PH_TIE4B: begin
            if (res_i.tie && res_i.dir_ne) begin
              n_d     = SW'(3);
              phase_d = bis_pkg::PH_MIN;
            end else begin
              phase_d = bis_pkg::PH_TIE4C;
            end
          end
          bis_pkg::PH_TIE4C: begin
            if (res_i.tie && res_i.dir_ne) begin
              n_d     = SW'(3);
              phase_d = bis_pkg::PH_MIN;
            end else begin
              resp_o.done = 1'b1;
              state_d     = bis_pkg::ST_IDLE;
            end
          end
          bis_pkg::PH_MIN: begin
            blk_o.init   = (i_q == '0);
            blk_o.wr_min = 1'b1;
            if (res_i.lt) m_d = i_q;
            if ((i_q + SW'(1)) == n_q) begin
              if (n_q == SW'(1)) begin
                resp_o.done = 1'b1;
                resp_o.ok   = 1'b1;
                state_d     = bis_pkg::ST_IDLE;
              end else begin
                phase_d = bis_pkg::PH_IV1;
              end
            end else begin
              i_d = i_q + SW'(1);
            end
          end
          bis_pkg::PH_IV1: begin
            if (n_q == SW'(5) && res_i.dir_ne) begin
              phase_d = bis_pkg::PH_IV1X;
            end else begin
              blk_o.wr_a = 1'b1;
              if (n_q == SW'(5)) begin
                alt_d   = 1'b0;
                phase_d = bis_pkg::PH_IV2;
              end else begin
                resp_o.done = 1'b1;
                resp_o.ok   = 1'b1;
                state_d     = bis_pkg::ST_IDLE;
              end
            end
          end
          bis_pkg::PH_IV1X: begin
            blk_o.wr_a = 1'b1;
            alt_d      = 1'b1;
            phase_d    = bis_pkg::PH_IV2;
          end
          bis_pkg::PH_IV2: begin
            blk_o.wr_b  = 1'b1;
            resp_o.done = 1'b1;
            resp_o.ok   = 1'b1;
            state_d     = bis_pkg::ST_IDLE;
          end
          default: begin
            resp_o.done = 1'b1;
            state_d     = bis_pkg::ST_IDLE;
          end
        endcase
      end

      default: begin
        state_d = bis_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != bis_pkg::ST_IDLE);

`ifndef ASSERT_OFF
  // every evaluate step follows a read step
  a_ex_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bis_pkg::ST_EX |-> $past(state_q) == bis_pkg::ST_RD)
    else $error("evaluate step without a preceding read");

  // a status result always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_o.done |=> state_q == bis_pkg::ST_IDLE)
    else $error("sequencer still busy after status");

  // staging writes happen only while idle and below capacity
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (state_q == bis_pkg::ST_IDLE) && (cnt_q < SW'(bis_pkg::MAX_PROFILES)))
    else $error("staging write out of place");

  // load count stays within the overflow mark
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bis_pkg::CNT_OVERFLOW)
    else $error("load count out of range");

  // block intervals are written only during calculation
  a_blk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_o.wr_a || blk_o.wr_b || blk_o.wr_min) |-> state_q == bis_pkg::ST_EX)
    else $error("block write outside calculation");
`endif

endmodule

@@ verif/bis_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_tb_pkg: scoreboard for the blocked interval selector bench
// Tracks staged profiles, tolerances and the current block, and predicts
// the status of every calculation and the answer of every time query.
// ----------------------------------------------------------------------------
package bis_tb_pkg;

  import bis_pkg::*;

  localparam int TIME_W = 48;

  // register index beyond the last tolerance; the block ignores writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef logic [TIME_W-1:0] tb_time_t;

  typedef struct packed {
    logic              v;
    tb_time_t          lo;
    tb_time_t          hi;
    logic [SLOT_W-1:0] slot;
  } span_t;

  typedef struct packed {
    logic              valid;
    tb_time_t          min_time;
    logic [SLOT_W-1:0] min_slot;
    span_t             a;
    span_t             b;
  } block_t;

  typedef struct packed {
    logic              resp_kind;
    logic              calc_ok;
    logic              blocked;
    logic              profile_valid;
    logic [SLOT_W-1:0] profile_slot;
  } response_t;

  class interval_scoreboard;

    logic [TOL_W-1:0] tol_pair, tol_near, tol_far;
    tb_time_t         staged_dur [MAX_PROFILES];
    logic             staged_dir [MAX_PROFILES];
    int               staged_cnt;
    block_t           blk;
    response_t        expected_responses [$];

    int errors, n_calc, n_calc_ok, n_query, n_blocked, n_overflow;
    int set_sizes [8];

    function new();
      tol_pair   = TOL_RESET;
      tol_near   = TOL_RESET;
      tol_far    = TOL_RESET;
      staged_cnt = 0;
      blk        = '0;
      errors     = 0;
      n_calc     = 0;
      n_calc_ok  = 0;
      n_query    = 0;
      n_blocked  = 0;
      n_overflow = 0;
      foreach (set_sizes[i]) set_sizes[i] = 0;
      foreach (staged_dur[i]) begin
        staged_dur[i] = '0;
        staged_dir[i] = 1'b0;
      end
    endfunction

    function void write_tol(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
      case (idx)
        CFG_TIE_PAIR: tol_pair = val;
        CFG_TIE_NEAR: tol_near = val;
        CFG_TIE_FAR:  tol_far  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    function tb_time_t gap_of(tb_time_t x, tb_time_t y);
      return (x > y) ? x - y : y - x;
    endfunction

    // the later end of the pair names the slot
    function span_t make_span(tb_time_t dl, logic [SLOT_W-1:0] sl, tb_time_t dr,
                              logic [SLOT_W-1:0] sr);
      span_t s;
      s.v = 1'b1;
      if (dl < dr) begin
        s.lo = dl; s.hi = dr; s.slot = sr;
      end else begin
        s.lo = dr; s.hi = dl; s.slot = sl;
      end
      return s;
    endfunction

    function bit compute_block(int n, output block_t nb);
      tb_time_t          d  [MAX_PROFILES];
      logic              dr [MAX_PROFILES];
      logic [SLOT_W-1:0] sl [MAX_PROFILES];
      int                k, m, e1, e2, e3, e4;
      nb = '0;
      if (n < 1 || n > MAX_PROFILES) return 1'b0;
      for (int i = 0; i < n; i++) begin
        d[i]  = staged_dur[i];
        dr[i] = staged_dir[i];
        sl[i] = SLOT_W'(i);
      end
      nb.valid = 1'b1;
      if (n == 1) begin
        nb.min_time = d[0]; nb.min_slot = sl[0];
        return 1'b1;
      end
      if (n == 2) begin
        if (gap_of(d[0], d[1]) < tol_pair) begin
          nb.min_time = d[0]; nb.min_slot = sl[0];
          return 1'b1;
        end
        m = (d[0] < d[1]) ? 0 : 1;
        nb.min_time = d[m]; nb.min_slot = sl[m];
        nb.a = make_span(d[m], sl[m], d[m ^ 1], sl[m ^ 1]);
        return 1'b1;
      end
      if (n == 4) begin
        // drop one side of a mirrored pair, or fail
        if (gap_of(d[0], d[1]) < tol_near && dr[0] != dr[1])     k = 1;
        else if (gap_of(d[2], d[3]) < tol_far && dr[2] != dr[3]) k = 3;
        else if (gap_of(d[0], d[3]) < tol_far && dr[0] != dr[3]) k = 3;
        else return 1'b0;
        for (int i = k; i + 1 < n; i++) begin
          d[i] = d[i + 1]; dr[i] = dr[i + 1]; sl[i] = sl[i + 1];
        end
        n = 3;
      end
      m = 0;
      for (int i = 1; i < n; i++) if (d[i] < d[m]) m = i;
      nb.min_time = d[m]; nb.min_slot = sl[m];
      if (n == 3) begin
        e1 = (m + 1) % 3; e2 = (m + 2) % 3;
        nb.a = make_span(d[e1], sl[e1], d[e2], sl[e2]);
        return 1'b1;
      end
      e1 = (m + 1) % 5; e2 = (m + 2) % 5; e3 = (m + 3) % 5; e4 = (m + 4) % 5;
      if (dr[e1] == dr[e2]) begin
        nb.a = make_span(d[e1], sl[e1], d[e2], sl[e2]);
        nb.b = make_span(d[e3], sl[e3], d[e4], sl[e4]);
      end else begin
        nb.a = make_span(d[e1], sl[e1], d[e4], sl[e4]);
        nb.b = make_span(d[e2], sl[e2], d[e3], sl[e3]);
      end
      return 1'b1;
    endfunction

    // advance the prediction by one accepted command
    function void note_command(logic kind, tb_time_t dur, logic dirn, logic last,
                               tb_time_t qt);
      response_t r;
      block_t    nb;
      r = '0;
      if (kind == KIND_LOAD) begin
        if (staged_cnt < MAX_PROFILES) begin
          staged_dur[staged_cnt] = dur;
          staged_dir[staged_cnt] = dirn;
          staged_cnt++;
        end else begin
          staged_cnt = int'(CNT_OVERFLOW);
        end
        if (!last) return;
        r.resp_kind = RESP_STATUS;
        set_sizes[staged_cnt]++;
        if (staged_cnt > MAX_PROFILES) n_overflow++;
        if (staged_cnt <= MAX_PROFILES && compute_block(staged_cnt, nb)) begin
          blk = nb;
          r.calc_ok = 1'b1;
          n_calc_ok++;
        end
        n_calc++;
        staged_cnt = 0;
      end else begin
        r.resp_kind     = RESP_QUERY;
        r.profile_valid = blk.valid;
        if (!blk.valid) begin
          r.blocked = 1'b1;
        end else begin
          r.blocked = (qt < blk.min_time)
                   || (blk.a.v && blk.a.lo < qt && qt < blk.a.hi)
                   || (blk.b.v && blk.b.lo < qt && qt < blk.b.hi);
          if (blk.b.v && qt >= blk.b.hi)      r.profile_slot = blk.b.slot;
          else if (blk.a.v && qt >= blk.a.hi) r.profile_slot = blk.a.slot;
          else                                r.profile_slot = blk.min_slot;
        end
        n_query++;
        if (r.blocked) n_blocked++;
      end
      expected_responses.push_back(r);
    endfunction

    function void check_response(response_t got);
      response_t exp_r;
      if (expected_responses.size() == 0) begin
        $error("result with no outstanding command: kind %0d", got.resp_kind);
        errors++;
        return;
      end
      exp_r = expected_responses.pop_front();
      if (got.resp_kind !== exp_r.resp_kind) begin
        $error("resp_kind mismatch: expected %0d, got %0d", exp_r.resp_kind, got.resp_kind);
        errors++;
      end
      if (got.calc_ok !== exp_r.calc_ok) begin
        $error("calc_ok mismatch: expected %0d, got %0d", exp_r.calc_ok, got.calc_ok);
        errors++;
      end
      if (got.blocked !== exp_r.blocked) begin
        $error("blocked mismatch: expected %0d, got %0d", exp_r.blocked, got.blocked);
        errors++;
      end
      if (got.profile_valid !== exp_r.profile_valid) begin
        $error("profile_valid mismatch: expected %0d, got %0d",
               exp_r.profile_valid, got.profile_valid);
        errors++;
      end
      if (got.profile_slot !== exp_r.profile_slot) begin
        $error("profile_slot mismatch: expected %0d, got %0d",
               exp_r.profile_slot, got.profile_slot);
        errors++;
      end
    endfunction

    function void check_drained();
      if (expected_responses.size() != 0) begin
        $error("%0d expected results never arrived", expected_responses.size());
        errors++;
      end
    endfunction

  endclass

endpackage

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for blocked_interval_selector
// Drives profile sets and time queries with random gaps, predicts every
// status and query answer with a scoreboard, and sweeps the tie tolerances.
// ----------------------------------------------------------------------------
module testbench;

  import bis_pkg::*;
  import bis_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 130;   // random commands per tolerance setting
  localparam int DRAIN_CYCLES = 24;    // longest calculation plus margin

  // one second and a few multiples in Q16.32
  localparam tb_time_t SEC1 = 48'h0001_0000_0000;
  localparam tb_time_t SEC2 = 48'h0002_0000_0000;
  localparam tb_time_t SEC3 = 48'h0003_0000_0000;
  localparam tb_time_t SEC4 = 48'h0004_0000_0000;
  localparam tb_time_t SEC5 = 48'h0005_0000_0000;
  localparam tb_time_t TMAX = '1;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              kind_i;
  tb_time_t          duration_i;
  logic              direction_i;
  logic              last_i;
  tb_time_t          query_time_i;
  logic              done_o;
  logic              resp_kind_o;
  logic              calc_ok_o;
  logic              blocked_o;
  logic              profile_valid_o;
  logic [SLOT_W-1:0] profile_slot_o;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [TOL_W-1:0]  cfg_wdata_i;

  interval_scoreboard sb;
  int  cycle_count = 0;
  int  phase_items;
  bit  burst;           // while set, the sender issues back to back

  blocked_interval_selector #(
    .TIME_BITS(TIME_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .duration_i     (duration_i),
    .direction_i    (direction_i),
    .last_i         (last_i),
    .query_time_i   (query_time_i),
    .done_o         (done_o),
    .resp_kind_o    (resp_kind_o),
    .calc_ok_o      (calc_ok_o),
    .blocked_o      (blocked_o),
    .profile_valid_o(profile_valid_o),
    .profile_slot_o (profile_slot_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop: the slowest correct run is a small fraction of this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Results cannot be held off: take every strobe at the edge that ends it.
  always @(posedge clk_i) begin
    response_t seen;
    if (rst_ni && done_o === 1'b1) begin
      seen.resp_kind     = resp_kind_o;
      seen.calc_ok       = calc_ok_o;
      seen.blocked       = blocked_o;
      seen.profile_valid = profile_valid_o;
      seen.profile_slot  = profile_slot_o;
      sb.check_response(seen);
    end
  end

  function automatic tb_time_t rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  // Present one command: idle for a random gap, then hold start until the
  // block takes the transfer. start stays high into the next command when
  // no gap follows, so the block sees back-to-back traffic.
  task automatic issue(logic kind, tb_time_t dur, logic dirn, logic last, tb_time_t qt);
    int gap;
    if ($urandom_range(0, 15) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i      = 1'b1;
    kind_i       = kind;
    duration_i   = dur;
    direction_i  = dirn;
    last_i       = last;
    query_time_i = qt;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_command(kind, dur, dirn, last, qt);
    phase_items++;
  endtask

  // query_time is a don't-care on loads; keep it toggling anyway
  task automatic load_profile(tb_time_t dur, logic dirn, logic last);
    issue(KIND_LOAD, dur, dirn, last, rand48());
  endtask

  task automatic ask(tb_time_t qt);
    issue(KIND_QUERY, rand48(), 1'($urandom), 1'($urandom), qt);
  endtask

  // Aim queries at block edges, zero, the top or random; exact or one LSB off.
  function automatic tb_time_t probe_time();
    tb_time_t t;
    case ($urandom_range(0, 8))
      0: t = sb.blk.min_time;
      1: t = sb.blk.a.lo;
      2: t = sb.blk.a.hi;
      3: t = sb.blk.b.lo;
      4: t = sb.blk.b.hi;
      5: t = '0;
      6: t = TMAX;
      default: t = rand48();
    endcase
    case ($urandom_range(0, 2))
      0: t = t - 1'b1;
      1: t = t + 1'b1;
      default: ;
    endcase
    return t;
  endfunction

  // Drop start, let every outstanding result arrive, then let a calculation
  // that is still finishing wind down before touching the registers.
  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tol(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    sb.write_tol(idx, val);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = TOL_W'($urandom);
  endtask

  task automatic write_all_tols(logic [TOL_W-1:0] pair, logic [TOL_W-1:0] near,
                                logic [TOL_W-1:0] far);
    settle();
    write_tol(CFG_TIE_PAIR, pair);
    write_tol(CFG_TIE_NEAR, near);
    write_tol(CFG_TIE_FAR, far);
  endtask

  // One profile set with random content. Most sets are well formed (one to
  // five loads), durations cluster so that ties and near ties show up, and
  // four-profile sets usually carry a mirrored pair so they get past the
  // pairing check. A few sets overflow; stray queries land mid-set.
  task automatic random_set();
    int          n, a, b;
    bit          spread_all;
    int unsigned spread;
    tb_time_t    base;
    tb_time_t    durs [7];
    logic        dirs [7];
    n = $urandom_range(0, 19);
    n = (n == 0) ? $urandom_range(6, 7) : 1 + (n % 5);
    base       = rand48();
    spread_all = 1'b0;
    case ($urandom_range(0, 3))
      0: spread = 3;
      1: spread = 70000;
      2: spread = 32'h00ff_ffff;
      default: begin
        spread     = 0;
        spread_all = 1'b1;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      durs[i] = spread_all ? rand48() : base + $urandom_range(0, spread);
      dirs[i] = 1'($urandom);
    end
    if (n == 4 && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 2))
        0: begin a = 0; b = 1; end
        1: begin a = 2; b = 3; end
        default: begin a = 0; b = 3; end
      endcase
      durs[b] = durs[a] + $urandom_range(0, 3);
      dirs[b] = !dirs[a];
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) ask(probe_time());
      load_profile(durs[i], dirs[i], i == n - 1);
    end
    repeat ($urandom_range(0, 4)) ask(probe_time());
  endtask

  task automatic random_phase();
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) random_set();
  endtask

  initial begin
    sb           = new();
    burst        = 1'b0;
    phase_items  = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = KIND_LOAD;
    duration_i   = '0;
    direction_i  = 1'b0;
    last_i       = 1'b0;
    query_time_i = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_TIE_PAIR;
    cfg_wdata_i  = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset tolerances.
    ask('0);                          // no block yet: blocked, no slot
    load_profile(TMAX, 1'b1, 1'b1);   // single profile at the top of the range
    ask('0);
    ask(TMAX);
    load_profile(SEC2, 1'b0, 1'b0);   // two equal durations collapse to slot 0
    load_profile(SEC2, 1'b1, 1'b1);
    load_profile('0, 1'b0, 1'b0);     // three, shortest at zero
    load_profile(SEC3, 1'b1, 1'b0);
    load_profile(SEC1, 1'b0, 1'b1);
    load_profile(SEC4, 1'b0, 1'b0);   // four, mirrored pair in slots zero and one
    load_profile(SEC4, 1'b1, 1'b0);
    load_profile(SEC2, 1'b0, 1'b0);
    load_profile(SEC5, 1'b1, 1'b1);
    load_profile(SEC5, 1'b0, 1'b0);   // five, two intervals
    load_profile(SEC1, 1'b0, 1'b0);
    load_profile(SEC4, 1'b1, 1'b0);
    load_profile(SEC3, 1'b1, 1'b0);
    load_profile(SEC2, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++)       // sixth load overflows: block kept
      load_profile(SEC1 + i, 1'b0, i == 5);
    ask(SEC3);

    // Sweep the tolerances: reset value, zero, full scale, small, random.
    random_phase();
    write_all_tols('0, '0, '0);
    random_phase();
    write_all_tols('1, '1, '1);
    random_phase();
    write_all_tols(16'd2, 16'd5, 16'd3);
    random_phase();
    write_all_tols(TOL_W'($urandom), TOL_W'($urandom), TOL_W'($urandom));
    write_tol(CFG_SPARE, TOL_W'($urandom));
    random_phase();

    settle();
    sb.check_drained();

    $display("Ran %0d calculations (%0d accepted, %0d overflowed) and %0d time queries",
             sb.n_calc, sb.n_calc_ok, sb.n_overflow, sb.n_query);
    $display("Set sizes 1..5: %0d %0d %0d %0d %0d; %0d queries found the time blocked",
             sb.set_sizes[1], sb.set_sizes[2], sb.set_sizes[3], sb.set_sizes[4],
             sb.set_sizes[5], sb.n_blocked);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
